[rtl/core/socd_pkg.sv]
// Shared types and constants for the direction cleaner.
// Used by socd_axis and socd_direction_cleaner_unit; no dependencies.
package socd_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_HORIZONTAL_MODE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_VERTICAL_MODE   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CHORD_MODE      = 2'd2;

   typedef enum logic [1:0] {
      MODE_NEUTRAL      = 2'd0,
      MODE_FIRST_WINS   = 2'd1,
      MODE_SECOND_WINS  = 2'd2,
      MODE_LAST_INPUT   = 2'd3
   } axis_mode_type;

   typedef enum logic [4:0] {
      AX_NEUTRAL     = 5'b00001,
      AX_FIRST       = 5'b00010,
      AX_FIRST_LOST  = 5'b00100,
      AX_SECOND      = 5'b01000,
      AX_SECOND_LOST = 5'b10000
   } axis_state_type;

   typedef struct packed {
      logic           first_out;
      logic           second_out;
      axis_state_type state;
   } axis_result_type;

endpackage

[rtl/core/socd_axis.sv]
// Opposing-press resolution for one axis: fixed rules and last-input machine.
// Depends on socd_pkg.
module socd_axis (
   input  socd_pkg::axis_mode_type   mode,
   input  logic                      force_last,
   input  logic                      first_pressed,
   input  logic                      second_pressed,
   input  logic                      first_held,
   input  logic                      second_held,
   input  socd_pkg::axis_state_type  state,
   output socd_pkg::axis_result_type result
);
   import socd_pkg::*;

   logic a;
   logic b;

   assign a = first_pressed;
   assign b = second_pressed;

   always_comb begin
      result.first_out  = first_held;
      result.second_out = second_held;
      result.state      = state;
      if (force_last || mode == MODE_LAST_INPUT) begin
         unique case (state)
            AX_NEUTRAL: begin
               if (a) begin
                  result.first_out = 1'b1;
                  result.state     = AX_FIRST;
               end else if (b) begin
                  result.second_out = 1'b1;
                  result.state      = AX_SECOND;
               end else begin
                  result.first_out  = 1'b0;
                  result.second_out = 1'b0;
               end
            end
            AX_FIRST: begin
               if (!a) begin
                  result.first_out = 1'b0;
                  result.state     = AX_NEUTRAL;
               end else if (b) begin
                  result.first_out  = 1'b0;
                  result.second_out = 1'b1;
                  result.state      = AX_FIRST_LOST;
               end else begin
                  result.first_out  = 1'b1;
                  result.second_out = 1'b0;
               end
            end
            AX_FIRST_LOST: begin
               if (!a) begin
                  result.first_out  = 1'b0;
                  result.second_out = 1'b1;
                  result.state      = AX_SECOND;
               end else if (!b) begin
                  result.first_out  = 1'b1;
                  result.second_out = 1'b0;
                  result.state      = AX_FIRST;
               end else begin
                  result.first_out  = 1'b0;
                  result.second_out = 1'b1;
               end
            end
            AX_SECOND: begin
               if (!b) begin
                  result.second_out = 1'b0;
                  result.state      = AX_NEUTRAL;
               end else if (a) begin
                  result.first_out  = 1'b1;
                  result.second_out = 1'b0;
                  result.state      = AX_SECOND_LOST;
               end else begin
                  result.first_out  = 1'b0;
                  result.second_out = 1'b1;
               end
            end
            AX_SECOND_LOST: begin
               if (!b) begin
                  result.first_out  = 1'b1;
                  result.second_out = 1'b0;
                  result.state      = AX_FIRST;
               end else if (!a) begin
                  result.first_out  = 1'b0;
                  result.second_out = 1'b1;
                  result.state      = AX_SECOND;
               end else begin
                  result.first_out  = 1'b1;
                  result.second_out = 1'b0;
               end
            end
            default: begin
               result.state = state;
            end
         endcase
      end else if (a && b) begin
         result.first_out  = (mode == MODE_FIRST_WINS);
         result.second_out = (mode == MODE_SECOND_WINS);
      end else begin
         result.first_out  = a;
         result.second_out = b;
      end
   end

endmodule

[rtl/core/socd_direction_cleaner_unit.sv]
// Direction cleaner top level: config registers, chord check, two axes, result register.
// Depends on socd_pkg and socd_axis.
// Result is valid the cycle after acceptance; one beat per cycle while rsp_ready holds.
// Cleaning state is updated at input acceptance, so a stalled result does not block it
// beyond the single result register; input ready drops only while that register is full.
// Synchronous active-high reset clears modes, axis states, held outputs and result valid.
module socd_direction_cleaner_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_left_level,
   input  logic                                  req_right_level,
   input  logic                                  req_down_level,
   input  logic                                  req_up_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_left_out,
   output logic                                  rsp_right_out,
   output logic                                  rsp_down_out,
   output logic                                  rsp_up_out,
   input  logic                                  csr_write_enable,
   input  logic [socd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [socd_pkg::CsrDataWidth-1:0]     csr_write_data
);
   import socd_pkg::*;

   axis_mode_type   horizontal_mode_ff;
   axis_mode_type   vertical_mode_ff;
   logic            chord_mode_ff;
   axis_state_type  horizontal_state_ff, horizontal_state_in;
   axis_state_type  vertical_state_ff, vertical_state_in;
   logic [3:0]      held_ff, held_in;
   logic            rsp_valid_ff;
   logic [3:0]      rsp_data_ff;
   logic            accept;
   logic            l, r, d, u;
   axis_result_type horizontal_result;
   axis_result_type vertical_result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign l = !req_left_level;
   assign r = !req_right_level;
   assign d = !req_down_level;
   assign u = !req_up_level;

   socd_axis u_horizontal (
      .mode           (horizontal_mode_ff),
      .force_last     (chord_mode_ff),
      .first_pressed  (l),
      .second_pressed (r),
      .first_held     (held_ff[0]),
      .second_held    (held_ff[1]),
      .state          (horizontal_state_ff),
      .result         (horizontal_result)
   );

   socd_axis u_vertical (
      .mode           (vertical_mode_ff),
      .force_last     (chord_mode_ff),
      .first_pressed  (d),
      .second_pressed (u),
      .first_held     (held_ff[2]),
      .second_held    (held_ff[3]),
      .state          (vertical_state_ff),
      .result         (vertical_result)
   );

   always_comb begin
      horizontal_state_in = horizontal_state_ff;
      vertical_state_in   = vertical_state_ff;
      priority if (chord_mode_ff && l && d && r) begin
         held_in = 4'b0100;
      end else if (chord_mode_ff && d && r && u) begin
         held_in = 4'b0010;
      end else if (chord_mode_ff && r && u && l) begin
         held_in = 4'b1000;
      end else if (chord_mode_ff && u && l && d) begin
         held_in = 4'b0001;
      end else begin
         held_in = {vertical_result.second_out, vertical_result.first_out,
                    horizontal_result.second_out, horizontal_result.first_out};
         horizontal_state_in = horizontal_result.state;
         vertical_state_in   = vertical_result.state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizontal_mode_ff  <= MODE_NEUTRAL;
         vertical_mode_ff    <= MODE_NEUTRAL;
         chord_mode_ff       <= 1'b0;
         horizontal_state_ff <= AX_NEUTRAL;
         vertical_state_ff   <= AX_NEUTRAL;
         held_ff             <= 4'b0000;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_HORIZONTAL_MODE) begin
               horizontal_mode_ff <= axis_mode_type'(csr_write_data);
            end else if (csr_index == CSR_VERTICAL_MODE) begin
               vertical_mode_ff <= axis_mode_type'(csr_write_data);
            end else if (csr_index == CSR_CHORD_MODE) begin
               chord_mode_ff <= csr_write_data[0];
            end
         end
         if (accept) begin
            horizontal_state_ff <= horizontal_state_in;
            vertical_state_ff   <= vertical_state_in;
            held_ff             <= held_in;
            rsp_valid_ff        <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= held_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_data_ff[0];
   assign rsp_right_out = rsp_data_ff[1];
   assign rsp_down_out  = rsp_data_ff[2];
   assign rsp_up_out    = rsp_data_ff[3];

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_data_ff == $past(held_in))
      else $error("accepted beat not registered");

   a_chord_down: assert property (@(posedge clock) disable iff (reset)
      accept && chord_mode_ff && l && d && r |=> rsp_data_ff == 4'b0100)
      else $error("left-down-right chord not forced to down");

   a_held_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff == held_ff)
      else $error("result differs from held outputs");
`endif

endmodule
